@@ rtl/core/npc_pkg.sv @@
// ----------------------------------------------------------------------------
// npc_pkg
// Shared types and constants for the nearest palette color search.
// ----------------------------------------------------------------------------
package npc_pkg;

	// squared rgb distance, max 3*255*255 fits in 18 bits
	localparam int unsigned DIST_W = 18;
	localparam logic [DIST_W-1:0] DIST_BOUND = DIST_W'(255 * 255 * 3);

	localparam int unsigned COMP_W  = 8;
	localparam int unsigned COLOR_W = 24;
	localparam int unsigned NUMC_W  = 9;
	localparam int unsigned OUT_W   = 8;

	// item codes
	typedef enum logic {
		CMD_LOAD  = 1'b0,
		CMD_QUERY = 1'b1
	} npc_op_t;

	// controller to datapath
	typedef struct packed {
		logic load;   // write palette entry from the item word
		logic start;  // latch query color, reset running best and address
		logic issue;  // read next palette entry
		logic take;   // copy running best into the result register
	} npc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic empty;  // search count is zero
		logic last;   // current read address is the last one to search
		logic busy;   // entries still in flight in the distance pipe
	} npc_stat_t;

endpackage

@@ rtl/core/npc_item_if.sv @@
// ----------------------------------------------------------------------------
// npc_item_if
// Input word channel: palette loads and color queries.
// ----------------------------------------------------------------------------
interface npc_item_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [7:0]  entry_index;
	logic [23:0] entry_color;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;

	modport source (
		output valid, cmd, entry_index, entry_color, red, green, blue,
		input  ready
	);
	modport sink (
		input  valid, cmd, entry_index, entry_color, red, green, blue,
		output ready
	);
endinterface

@@ rtl/core/npc_result_if.sv @@
// ----------------------------------------------------------------------------
// npc_result_if
// Output word channel: index of the nearest palette entry.
// ----------------------------------------------------------------------------
interface npc_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] best_index;

	modport source (
		output valid, best_index,
		input  ready
	);
	modport sink (
		input  valid, best_index,
		output ready
	);
endinterface

@@ rtl/core/npc_cfg_if.sv @@
// ----------------------------------------------------------------------------
// npc_cfg_if
// Configuration write channel for the num_colors register.
// ----------------------------------------------------------------------------
interface npc_cfg_if;
	logic       valid;
	logic       ready;
	logic [8:0] num_colors;

	modport source (
		output valid, num_colors,
		input  ready
	);
	modport sink (
		input  valid, num_colors,
		output ready
	);
endinterface

@@ rtl/core/npc_ctrl.sv @@
// ----------------------------------------------------------------------------
// npc_ctrl
// Sequencer: accepts words, steps the palette scan, drains the distance
// pipe and hands the answer to the output register.
// ----------------------------------------------------------------------------
module npc_ctrl
	import npc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	input  logic      item_cmd,
	output logic      item_ready,
	input  logic      result_ready,
	output logic      result_valid,
	output npc_cmd_t  cmd,
	input  npc_stat_t stat
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   item_acc;

	// handshake and commands
	assign item_ready   = (state_q == ST_IDLE);
	assign item_acc     = item_valid && item_ready;
	assign result_valid = out_valid_q;

	always_comb begin
		cmd.load  = item_acc && (npc_op_t'(item_cmd) == CMD_LOAD);
		cmd.start = item_acc && (npc_op_t'(item_cmd) == CMD_QUERY);
		cmd.issue = (state_q == ST_SCAN);
		cmd.take  = (state_q == ST_FINISH) && (!out_valid_q || result_ready);
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.take) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && result_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						state_q <= stat.empty ? ST_FINISH : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (stat.last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!stat.busy) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (cmd.take) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/core/npc_dpath.sv @@
// ----------------------------------------------------------------------------
// npc_dpath
// Palette memory, num_colors register, address counter, distance pipe
// and running minimum.
// ----------------------------------------------------------------------------
module npc_dpath
	import npc_pkg::*;
#(
	parameter int unsigned PALETTE_DEPTH = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	npc_item_if.sink        item,
	npc_cfg_if.sink         cfg,
	output logic [OUT_W-1:0] best_index,
	input  npc_cmd_t        cmd,
	output npc_stat_t       stat
);

	localparam int unsigned AW  = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
	localparam int unsigned CW  = $clog2(PALETTE_DEPTH + 1);
	localparam int unsigned MW  = (CW > NUMC_W) ? CW : NUMC_W;
	localparam int unsigned IW  = (AW > OUT_W) ? AW : OUT_W;

	logic [COLOR_W-1:0] mem [PALETTE_DEPTH];

	logic [NUMC_W-1:0] num_colors_q;
	logic [CW-1:0]     count;
	logic [MW-1:0]     nc_ext;
	logic [AW-1:0]     addr_q;
	logic              wr_ok;
	logic [IW:0]       wr_idx_ext;

	logic [COMP_W-1:0] red_q, green_q, blue_q;

	logic               v_s1, v_s2;
	logic [COLOR_W-1:0] color_s1;
	logic [AW-1:0]      idx_s1, idx_s2;
	logic [2*COMP_W-1:0] sq_r_s2, sq_g_s2, sq_b_s2;

	logic [DIST_W-1:0] best_dist_q;
	logic [AW-1:0]     best_idx_q;
	logic [DIST_W-1:0] dist_sum;
	logic [IW-1:0]     res_ext;
	logic [OUT_W-1:0]  res_q;

	// absolute difference of two components
	function automatic logic [COMP_W-1:0] abs_diff(input logic [COMP_W-1:0] a,
	                                              input logic [COMP_W-1:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	// config register, always ready
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_colors_q <= '0;
		end else if (cfg.valid) begin
			num_colors_q <= cfg.num_colors;
		end
	end

	// search count saturated to the palette depth
	always_comb begin
		nc_ext = MW'(num_colors_q);
		if (nc_ext > MW'(PALETTE_DEPTH)) begin
			count = CW'(PALETTE_DEPTH);
		end else begin
			count = CW'(nc_ext);
		end
	end

	assign stat.empty = (count == '0);
	assign stat.last  = ((CW'(addr_q) + CW'(1)) == count);
	assign stat.busy  = v_s1 || v_s2;

	// palette write, indexes beyond the depth are dropped
	assign wr_idx_ext = (IW + 1)'(item.entry_index);
	assign wr_ok      = wr_idx_ext < (IW + 1)'(PALETTE_DEPTH);

	always_ff @(posedge clk) begin
		if (cmd.load && wr_ok) begin
			mem[AW'(item.entry_index)] <= item.entry_color;
		end
		if (cmd.issue) begin
			color_s1 <= mem[addr_q];
		end
	end

	// read address counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
		end else if (cmd.start) begin
			addr_q <= '0;
		end else if (cmd.issue) begin
			addr_q <= addr_q + AW'(1);
		end
	end

	// pipe valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
		end
	end

	// query color latch
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			red_q   <= item.red;
			green_q <= item.green;
			blue_q  <= item.blue;
		end
	end

	// squared component differences
	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			idx_s1 <= addr_q;
		end
		if (v_s1) begin
			idx_s2  <= idx_s1;
			sq_r_s2 <= (2*COMP_W)'(abs_diff(red_q, color_s1[7:0]))
			         * (2*COMP_W)'(abs_diff(red_q, color_s1[7:0]));
			sq_g_s2 <= (2*COMP_W)'(abs_diff(green_q, color_s1[15:8]))
			         * (2*COMP_W)'(abs_diff(green_q, color_s1[15:8]));
			sq_b_s2 <= (2*COMP_W)'(abs_diff(blue_q, color_s1[23:16]))
			         * (2*COMP_W)'(abs_diff(blue_q, color_s1[23:16]));
		end
	end

	// sum and running minimum, first strictly smaller wins
	assign dist_sum = DIST_W'(sq_r_s2) + DIST_W'(sq_g_s2) + DIST_W'(sq_b_s2);

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			best_dist_q <= DIST_BOUND;
			best_idx_q  <= '0;
		end else if (v_s2 && (dist_sum < best_dist_q)) begin
			best_dist_q <= dist_sum;
			best_idx_q  <= idx_s2;
		end
	end

	// result register, low byte of the index
	assign res_ext = IW'(best_idx_q);

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			res_q <= res_ext[OUT_W-1:0];
		end
	end

	assign best_index = res_q;

endmodule

@@ rtl/core/nearest_palette_color_core.sv @@
// Load word: writes a palette entry and gives no result.
// Query: the result is registered once the scan ends and the distance pipe has drained.
// No new word is taken until the last query's result is in the output register;
// the scan reads one palette entry a cycle through the memory's single read port.
// Reset clears control and num_colors; palette contents are undefined until written.
// ----------------------------------------------------------------------------
// nearest_palette_color_core
// Nearest palette color search by squared rgb distance over a loadable
// palette, built as a sequencer and a scanning datapath.
// ----------------------------------------------------------------------------
module nearest_palette_color_core
	import npc_pkg::*;
#(
	parameter int unsigned PALETTE_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	npc_item_if.sink    item,
	npc_result_if.source result,
	npc_cfg_if.sink     cfg
);

	npc_cmd_t  cmd;
	npc_stat_t stat;

	// sequencer
	npc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item.valid),
		.item_cmd     (item.cmd),
		.item_ready   (item.ready),
		.result_ready (result.ready),
		.result_valid (result.valid),
		.cmd          (cmd),
		.stat         (stat)
	);

	// palette and distance datapath
	npc_dpath #(
		.PALETTE_DEPTH (PALETTE_DEPTH)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.cfg        (cfg),
		.best_index (result.best_index),
		.cmd        (cmd),
		.stat       (stat)
	);

endmodule
